>>> design/cot_pkg.sv
// Shared constants for the capsule overlap test.
`default_nettype none
package cot_pkg;
    localparam int RADIUS_BITS = 20;
    localparam int RSUM_BITS   = RADIUS_BITS + 1;
    localparam int RSQ_BITS    = 2 * RSUM_BITS;
    localparam int LANES       = 4;

    // nearest-point case of one endpoint test
    localparam logic [1:0] NEAR_START = 2'd0;
    localparam logic [1:0] NEAR_END   = 2'd1;
    localparam logic [1:0] NEAR_MID   = 2'd2;
endpackage
`default_nettype wire

>>> design/cot_pair_if.sv
// Channel carrying one capsule pair.
`default_nettype none
interface cot_pair_if
    import cot_pkg::*;
#(
    parameter int COORD_BITS = 24
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] first_start_x;
    logic signed [COORD_BITS-1:0] first_start_y;
    logic signed [COORD_BITS-1:0] first_end_x;
    logic signed [COORD_BITS-1:0] first_end_y;
    logic [RADIUS_BITS-1:0]       first_radius;
    logic signed [COORD_BITS-1:0] second_start_x;
    logic signed [COORD_BITS-1:0] second_start_y;
    logic signed [COORD_BITS-1:0] second_end_x;
    logic signed [COORD_BITS-1:0] second_end_y;
    logic [RADIUS_BITS-1:0]       second_radius;

    modport source (output valid, first_start_x, first_start_y, first_end_x, first_end_y,
                    first_radius, second_start_x, second_start_y, second_end_x,
                    second_end_y, second_radius, input ready);
    modport sink (input valid, first_start_x, first_start_y, first_end_x, first_end_y,
                  first_radius, second_start_x, second_start_y, second_end_x,
                  second_end_y, second_radius, output ready);
endinterface
`default_nettype wire

>>> design/cot_result_if.sv
// Channel carrying one overlap verdict.
`default_nettype none
interface cot_result_if;
    logic valid;
    logic ready;
    logic overlap;

    modport source (output valid, overlap, input ready);
    modport sink (input valid, overlap, output ready);
endinterface
`default_nettype wire

>>> design/capsule_overlap_test_core.sv
// Capsule overlap test: pipelined four-lane endpoint test for 2D capsule pairs.
//
// Usage
//   pair   : sink channel, one word is two capsules (segment ends plus radius).
//   result : source channel, one word per pair, overlap = 1 when any lane hits.
//   A word is moved when valid and ready are both high at a rising clock edge.
// Timing
//   Six register stages. One pair is accepted per cycle while result is
//   taken, sustained by the stage chain (differences, products, sums,
//   split partial products, partial sums, compare) with every multiply
//   at most 25 by 25 bits.
// Reset
//   rst_n low clears every valid bit; no words are in flight afterwards.
// Stalls
//   When result is not taken, the output word holds and each stage holds
//   only while the stage after it is full, so bubbles close up and pair
//   stays ready until the pipeline is full. Nothing is dropped or repeated.
// Lanes test each endpoint of one capsule against the other's segment using
// dot and cross products, so no division or root is needed.
`default_nettype none
module capsule_overlap_test_core
    import cot_pkg::*;
#(
    parameter int COORD_BITS = 24
)(
    input  wire logic       clk,
    input  wire logic       rst_n,
    cot_pair_if.sink        pair,
    cot_result_if.source    result
);
    localparam int C  = COORD_BITS;
    localparam int D  = C + 1;           // coordinate difference
    localparam int P  = 2 * D;           // product of two differences
    localparam int W  = 2 * C + 3;       // signed dot / cross
    localparam int N  = 2 * C + 2;       // unsigned squared length
    localparam int H  = (N + 1) / 2;     // low half of a split operand
    localparam int HI = N - H;           // high half
    localparam int RL = RSQ_BITS / 2;
    localparam int RH = RSQ_BITS - RL;
    localparam int Q  = 2 * N + RSQ_BITS;

    // stage valid bits and load enables
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, ov_reg;
    logic en1, en2, en3, en4, en5, en6;

    assign en6 = !ov_reg || result.ready;
    assign en5 = !v5_reg || en6;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign pair.ready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= pair.valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
            if (en6) ov_reg <= v5_reg;
        end
    end

    // lane operands: point and segment of each endpoint test
    logic signed [C-1:0] px [LANES];
    logic signed [C-1:0] py [LANES];
    logic signed [C-1:0] sx [LANES];
    logic signed [C-1:0] sy [LANES];
    logic signed [C-1:0] ex [LANES];
    logic signed [C-1:0] ey [LANES];

    assign px[0] = pair.second_start_x;  assign py[0] = pair.second_start_y;
    assign px[1] = pair.second_end_x;    assign py[1] = pair.second_end_y;
    assign px[2] = pair.first_start_x;   assign py[2] = pair.first_start_y;
    assign px[3] = pair.first_end_x;     assign py[3] = pair.first_end_y;
    assign sx[0] = pair.first_start_x;   assign sy[0] = pair.first_start_y;
    assign sx[1] = pair.first_start_x;   assign sy[1] = pair.first_start_y;
    assign sx[2] = pair.second_start_x;  assign sy[2] = pair.second_start_y;
    assign sx[3] = pair.second_start_x;  assign sy[3] = pair.second_start_y;
    assign ex[0] = pair.first_end_x;     assign ey[0] = pair.first_end_y;
    assign ex[1] = pair.first_end_x;     assign ey[1] = pair.first_end_y;
    assign ex[2] = pair.second_end_x;    assign ey[2] = pair.second_end_y;
    assign ex[3] = pair.second_end_x;    assign ey[3] = pair.second_end_y;

    // shared radius path
    logic [RSUM_BITS-1:0] rsum_reg;
    logic [RSQ_BITS-1:0]  rsq_reg, rsq3_reg;

    always_ff @(posedge clk)
    begin
        if (en1) rsum_reg <= RSUM_BITS'(pair.first_radius) + RSUM_BITS'(pair.second_radius);
        if (en2) rsq_reg  <= RSQ_BITS'(rsum_reg) * RSQ_BITS'(rsum_reg);
        if (en3) rsq3_reg <= rsq_reg;
    end

    logic [LANES-1:0] hit;

    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        // stage 1: differences
        logic signed [D-1:0] lx_reg, ly_reg, a1x_reg, a1y_reg, a2x_reg, a2y_reg;
        // stage 2: products
        logic signed [P-1:0] la1x_reg, la1y_reg, la2x_reg, la2y_reg;
        logic signed [P-1:0] a1xx_reg, a1yy_reg, a2xx_reg, a2yy_reg;
        logic signed [P-1:0] lxx_reg, lyy_reg, cxa_reg, cxb_reg;
        // stage 3: sums
        logic signed [W-1:0] d1, d2, cr;
        logic [N-1:0]        crabs;
        logic [N-1:0]        n1_reg, n2_reg, len_reg, crabs_reg;
        logic [1:0]          near_reg;
        // stage 4: split partial products
        logic [2*HI-1:0]     hh_reg;
        logic [HI+H-1:0]     hl_reg;
        logic [2*H-1:0]      ll_reg;
        logic [RH+HI-1:0]    rhlh_reg;
        logic [RH+H-1:0]     rhll_reg;
        logic [RL+HI-1:0]    rllh_reg;
        logic [RL+H-1:0]     rlll_reg;
        logic                mid4_reg, end4_reg;
        logic [N-1:0]        nsel;
        // stage 5: partial sums
        logic [Q-1:0]        lhs_reg, rhs_reg;
        logic                mid5_reg, end5_reg;

        always_ff @(posedge clk)
        begin
            if (en1)
            begin
                lx_reg  <= D'(ex[l]) - D'(sx[l]);
                ly_reg  <= D'(ey[l]) - D'(sy[l]);
                a1x_reg <= D'(px[l]) - D'(sx[l]);
                a1y_reg <= D'(py[l]) - D'(sy[l]);
                a2x_reg <= D'(px[l]) - D'(ex[l]);
                a2y_reg <= D'(py[l]) - D'(ey[l]);
            end
        end

        always_ff @(posedge clk)
        begin
            if (en2)
            begin
                la1x_reg <= P'(lx_reg) * P'(a1x_reg);
                la1y_reg <= P'(ly_reg) * P'(a1y_reg);
                la2x_reg <= P'(lx_reg) * P'(a2x_reg);
                la2y_reg <= P'(ly_reg) * P'(a2y_reg);
                a1xx_reg <= P'(a1x_reg) * P'(a1x_reg);
                a1yy_reg <= P'(a1y_reg) * P'(a1y_reg);
                a2xx_reg <= P'(a2x_reg) * P'(a2x_reg);
                a2yy_reg <= P'(a2y_reg) * P'(a2y_reg);
                lxx_reg  <= P'(lx_reg) * P'(lx_reg);
                lyy_reg  <= P'(ly_reg) * P'(ly_reg);
                cxa_reg  <= P'(lx_reg) * P'(a1y_reg);
                cxb_reg  <= P'(ly_reg) * P'(a1x_reg);
            end
        end

        assign d1    = W'(la1x_reg) + W'(la1y_reg);
        assign d2    = W'(la2x_reg) + W'(la2y_reg);
        assign cr    = W'(cxa_reg) - W'(cxb_reg);
        assign crabs = cr[W-1] ? N'(-cr) : N'(cr);

        always_ff @(posedge clk)
        begin
            if (en3)
            begin
                n1_reg    <= N'(a1xx_reg) + N'(a1yy_reg);
                n2_reg    <= N'(a2xx_reg) + N'(a2yy_reg);
                len_reg   <= N'(lxx_reg) + N'(lyy_reg);
                crabs_reg <= crabs;
                if (d1[W-1] || d1 == '0)
                    near_reg <= NEAR_START;
                else if (!d2[W-1])
                    near_reg <= NEAR_END;
                else
                    near_reg <= NEAR_MID;
            end
        end

        // pick the endpoint distance for the clamped cases
        always_comb
        begin
            unique case (near_reg)
                NEAR_START: nsel = n1_reg;
                NEAR_END:   nsel = n2_reg;
                default:    nsel = n1_reg;
            endcase
        end

        always_ff @(posedge clk)
        begin
            if (en4)
            begin
                hh_reg   <= (2*HI)'(crabs_reg[N-1:H]) * (2*HI)'(crabs_reg[N-1:H]);
                hl_reg   <= (HI+H)'(crabs_reg[N-1:H]) * (HI+H)'(crabs_reg[H-1:0]);
                ll_reg   <= (2*H)'(crabs_reg[H-1:0]) * (2*H)'(crabs_reg[H-1:0]);
                rhlh_reg <= (RH+HI)'(rsq3_reg[RSQ_BITS-1:RL]) * (RH+HI)'(len_reg[N-1:H]);
                rhll_reg <= (RH+H)'(rsq3_reg[RSQ_BITS-1:RL]) * (RH+H)'(len_reg[H-1:0]);
                rllh_reg <= (RL+HI)'(rsq3_reg[RL-1:0]) * (RL+HI)'(len_reg[N-1:H]);
                rlll_reg <= (RL+H)'(rsq3_reg[RL-1:0]) * (RL+H)'(len_reg[H-1:0]);
                mid4_reg <= (near_reg == NEAR_MID);
                end4_reg <= (Q'(nsel) <= Q'(rsq3_reg));
            end
        end

        always_ff @(posedge clk)
        begin
            if (en5)
            begin
                lhs_reg  <= (Q'(hh_reg) << (2*H)) + (Q'(hl_reg) << (H+1)) + Q'(ll_reg);
                rhs_reg  <= (Q'(rhlh_reg) << (RL+H)) + (Q'(rhll_reg) << RL)
                          + (Q'(rllh_reg) << H) + Q'(rlll_reg);
                mid5_reg <= mid4_reg;
                end5_reg <= end4_reg;
            end
        end

        assign hit[l] = mid5_reg ? (lhs_reg <= rhs_reg) : end5_reg;
    end

    // output word
    logic overlap_reg;

    always_ff @(posedge clk)
    begin
        if (en6) overlap_reg <= |hit;
    end

    assign result.valid   = ov_reg;
    assign result.overlap = overlap_reg;

    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (pair.valid && pair.ready) |=> v1_reg)
        else $error("accepted pair did not enter stage one");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && v2_reg && v3_reg && v4_reg && v5_reg && ov_reg && !result.ready)
        |-> !pair.ready)
        else $error("pair taken while pipeline full and stalled");

    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ov_reg) |-> $past(v5_reg))
        else $error("result word appeared without a stage five word");

endmodule
`default_nettype wire
